[hw/rtl/fba_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes, handshake structs and helpers of the frame bitmap allocator.
package fba_pkg;

	localparam int MAX_FRAMES    = 4096;
	localparam int MAP_WORD_BITS = 32;
	localparam int WORD_CNT      = MAX_FRAMES / MAP_WORD_BITS;
	localparam int WORD_AW       = $clog2(WORD_CNT);
	localparam int BIT_AW        = $clog2(MAP_WORD_BITS);
	localparam int TOT_W         = 13;
	localparam int FRAME_W       = 16;
	localparam int GRANT_W       = 12;
	localparam int OP_W          = 2;
	localparam int NW_W          = TOT_W - BIT_AW;

	localparam logic [TOT_W-1:0] MAX_FRAMES_C = TOT_W'(MAX_FRAMES);
	localparam logic [TOT_W-1:0] TALLY_MAX    = '1;

	localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

	typedef logic [MAP_WORD_BITS-1:0] map_word_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic alloc_commit;
		logic free_rd;
		logic free_commit;
		logic load_out;
	} fba_cmd_t;

	typedef struct packed {
		logic hit;
		logic exhausted;
		logic out_space;
	} fba_sts_t;

	function automatic logic [BIT_AW-1:0] lowest_set(input map_word_t w);
		logic [BIT_AW-1:0] idx;
		idx = '0;
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_AW'(i);
			end
		end
		return idx;
	endfunction

endpackage

[hw/rtl/frame_bitmap_allocator_core.sv]
`timescale 1ns / 1ps
// Top level of the first-fit bitmap page-frame allocator.
//
// channel  | handshake              | word
// ---------+------------------------+------------------------------------------------
// input    | in_valid / in_ready    | opcode, frame_number
// output   | out_valid / out_ready  | ok, granted_frame, free_count, used_count
// config   | cfg_valid / cfg_ready  | total_frames
//
// Init and unused opcodes go from idle straight to the finish state; free passes a read and a check state first.
// Alloc scans the used map one 32-bit word per cycle through the map memory read port,
// stopping at the first word with a free frame, or after ceil(total/32) words when none is free.
// Reset marks every frame used at once through per-word valid bits; no clearing pass.
// A finished result waits in the output register; the next word is taken while it waits,
// and its result stalls in the last state until the output register frees.
module frame_bitmap_allocator_core
	import fba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    opcode,
	input  logic [FRAME_W-1:0] frame_number,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               ok,
	output logic [GRANT_W-1:0] granted_frame,
	output logic [TOT_W-1:0]   free_count,
	output logic [TOT_W-1:0]   used_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [TOT_W-1:0]   total_frames
);

	fba_cmd_t         cmd;
	fba_sts_t         sts;
	logic [TOT_W-1:0] total_frames_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_frames_q <= '0;
		end else if (cfg_valid) begin
			total_frames_q <= total_frames;
		end
	end

	fba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fba_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.opcode         (opcode),
		.frame_number   (frame_number),
		.total_frames_q (total_frames_q),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.ok             (ok),
		.granted_frame  (granted_frame),
		.free_count     (free_count),
		.used_count     (used_count)
	);

endmodule

[hw/rtl/fba_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine sequencing init, first-fit scan, free and result hand-off.
module fba_ctrl
	import fba_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] opcode,
	output logic            in_ready,
	input  fba_sts_t        sts,
	output fba_cmd_t        cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_FREE_RD  = 3'd2;
	localparam logic [2:0] S_FREE_CHK = 3'd3;
	localparam logic [2:0] S_FIN      = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					unique case (opcode)
						OP_ALLOC: state_d = S_SCAN;
						OP_FREE:  state_d = S_FREE_RD;
						default:  state_d = S_FIN;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.alloc_commit = 1'b1;
					state_d          = S_FIN;
				end else if (sts.exhausted) begin
					state_d = S_FIN;
				end
			end
			S_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_d     = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				cmd.free_commit = 1'b1;
				state_d         = S_FIN;
			end
			S_FIN: begin
				if (sts.out_space) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/fba_dp.sv]
`timescale 1ns / 1ps
// Datapath: used-map memory with per-word valid bits, scan pipeline, tally and output word.
module fba_dp
	import fba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [OP_W-1:0]    opcode,
	input  logic [FRAME_W-1:0] frame_number,
	input  logic [TOT_W-1:0]   total_frames_q,
	input  fba_cmd_t           cmd,
	output fba_sts_t           sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               ok,
	output logic [GRANT_W-1:0] granted_frame,
	output logic [TOT_W-1:0]   free_count,
	output logic [TOT_W-1:0]   used_count
);

	map_word_t map_mem [WORD_CNT];
	logic [WORD_CNT-1:0] map_vld_q;

	logic [FRAME_W-1:0] frame_q;
	logic [TOT_W-1:0]   tot_q;
	logic [TOT_W-1:0]   tally_q;
	logic               res_ok_q;
	logic [GRANT_W-1:0] res_grant_q;
	logic [NW_W-1:0]    rd_addr_q;

	logic               rd_vld_s1;
	logic [WORD_AW-1:0] chk_addr_s1;
	logic               vld_s1;
	map_word_t          mem_rd_s1;

	logic               out_valid_q;
	logic               ok_q;
	logic [GRANT_W-1:0] grant_q;
	logic [TOT_W-1:0]   free_q;
	logic [TOT_W-1:0]   used_q;

	logic [TOT_W-1:0]   tot_eff;
	logic [TOT_W-1:0]   tot_round;
	logic [NW_W-1:0]    nwords;
	logic               more;
	logic               issue;
	logic               mem_re;
	logic [WORD_AW-1:0] rd_addr;
	map_word_t          eff_word;
	map_word_t          lim_mask;
	map_word_t          free_bits;
	logic [BIT_AW-1:0]  hit_bit;
	map_word_t          hit_onehot;
	map_word_t          free_onehot;
	logic               free_good;
	logic               mem_we;
	logic [WORD_AW-1:0] wr_addr;
	map_word_t          wr_data;
	logic [TOT_W-1:0]   used_now;

	assign tot_eff   = (total_frames_q > MAX_FRAMES_C) ? MAX_FRAMES_C : total_frames_q;
	assign tot_round = tot_q + TOT_W'(MAP_WORD_BITS - 1);
	assign nwords    = tot_round[TOT_W-1:BIT_AW];
	assign more      = (rd_addr_q < nwords);

	assign eff_word = vld_s1 ? mem_rd_s1 : '1;
	always_comb begin
		if (tot_q[TOT_W-1] || (chk_addr_s1 < tot_q[TOT_W-2:BIT_AW])) begin
			lim_mask = '1;
		end else begin
			lim_mask = (map_word_t'(1) << tot_q[BIT_AW-1:0]) - map_word_t'(1);
		end
	end
	assign free_bits  = ~eff_word & lim_mask;
	assign hit_bit    = lowest_set(free_bits);
	assign hit_onehot = map_word_t'(1) << hit_bit;

	assign sts.hit       = rd_vld_s1 && (free_bits != '0);
	assign sts.exhausted = !rd_vld_s1 && !more;
	assign sts.out_space = !out_valid_q || out_ready;

	assign issue   = cmd.scan && !sts.hit && more;
	assign mem_re  = issue || cmd.free_rd;
	assign rd_addr = cmd.free_rd ? frame_q[BIT_AW+WORD_AW-1:BIT_AW] : rd_addr_q[WORD_AW-1:0];

	assign free_onehot = map_word_t'(1) << frame_q[BIT_AW-1:0];
	assign free_good   = (frame_q < FRAME_W'(tot_q)) && ((eff_word & free_onehot) != '0);

	assign mem_we  = cmd.alloc_commit || (cmd.free_commit && free_good);
	assign wr_addr = cmd.alloc_commit ? chk_addr_s1 : frame_q[BIT_AW+WORD_AW-1:BIT_AW];
	assign wr_data = cmd.alloc_commit ? (eff_word | hit_onehot) : (eff_word & ~free_onehot);

	assign used_now = (tot_q > tally_q) ? (tot_q - tally_q) : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			mem_rd_s1   <= map_mem[rd_addr];
			vld_s1      <= map_vld_q[rd_addr];
			chk_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			frame_q <= frame_number;
			tot_q   <= tot_eff;
		end
		if (cmd.load_out) begin
			ok_q    <= res_ok_q;
			grant_q <= res_grant_q;
			free_q  <= tally_q;
			used_q  <= used_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q   <= '0;
			tally_q     <= '0;
			res_ok_q    <= 1'b0;
			res_grant_q <= '0;
			rd_addr_q   <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_addr_q <= rd_addr_q + NW_W'(1);
			end
			if (cmd.start) begin
				rd_addr_q   <= '0;
				res_ok_q    <= (opcode == OP_INIT);
				res_grant_q <= '0;
				if (opcode == OP_INIT) begin
					map_vld_q <= '0;
					tally_q   <= '0;
				end
			end
			if (cmd.alloc_commit) begin
				map_vld_q[chk_addr_s1] <= 1'b1;
				res_ok_q               <= 1'b1;
				res_grant_q            <= {chk_addr_s1, hit_bit};
				if (tally_q != '0) begin
					tally_q <= tally_q - TOT_W'(1);
				end
			end
			if (cmd.free_commit && free_good) begin
				map_vld_q[frame_q[BIT_AW+WORD_AW-1:BIT_AW]] <= 1'b1;
				res_ok_q                                    <= 1'b1;
				if (tally_q != TALLY_MAX) begin
					tally_q <= tally_q + TOT_W'(1);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign granted_frame = grant_q;
	assign free_count    = free_q;
	assign used_count    = used_q;

endmodule
